/* src/imurb_pkg.sv */
package imurb_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_ROT_MATRIX   = 3'd0;
	localparam logic [2:0] REG_LEARN_ALPHA  = 3'd1;
	localparam logic [2:0] REG_TRACK_ALPHA  = 3'd2;
	localparam logic [2:0] REG_LEARN_LIMIT  = 3'd3;
	localparam logic [2:0] REG_ACCEL_STILL  = 3'd4;
	localparam logic [2:0] REG_GYRO_STILL   = 3'd5;

	// Register reset values; the matrix reset is the identity
	localparam logic [17:0] ROT_MATRIX_RST  = 18'h10101;
	localparam logic [15:0] LEARN_ALPHA_RST = 16'd1311;
	localparam logic [15:0] TRACK_ALPHA_RST = 16'd7;
	localparam logic [15:0] LEARN_LIMIT_RST = 16'd500;
	localparam logic [31:0] ACCEL_STILL_RST = 32'd41943;
	localparam logic [31:0] GYRO_STILL_RST  = 32'd671089;

	localparam int NUM_AXES = 3;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic signed [15:0] compass_x;
		logic signed [15:0] compass_y;
		logic signed [15:0] compass_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] accel_out_x;
		logic signed [15:0] accel_out_y;
		logic signed [15:0] accel_out_z;
		logic signed [15:0] gyro_out_x;
		logic signed [15:0] gyro_out_y;
		logic signed [15:0] gyro_out_z;
		logic signed [15:0] compass_out_x;
		logic signed [15:0] compass_out_y;
		logic signed [15:0] compass_out_z;
	} out_item_t;

	// Three 16-bit components, index 0 is x
	typedef logic [2:0][15:0] vec3_t;

	typedef struct packed {
		logic [17:0] rotation_matrix;
		logic [15:0] learn_alpha;
		logic [15:0] track_alpha;
		logic [15:0] learn_sample_limit;
		logic [31:0] accel_still_sq;
		logic [31:0] gyro_still_sq;
	} cfg_t;

	// Stage strobes from the sequencer to the lanes
	typedef struct packed {
		logic rot_en;
		logic sq_en;
		logic mul_en;
		logic upd_en;
	} lane_ctl_t;

	// Squared terms that one lane hands to the merge stage
	typedef struct packed {
		logic [32:0] dsq;
		logic [30:0] gsq;
	} lane_sq_t;

	// Stillness decision that the merge stage hands back to the lanes
	typedef struct packed {
		logic        still;
		logic [15:0] alpha;
	} bias_ctl_t;

endpackage

/* src/imurb_lane.sv */
module imurb_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [5:0]          row,
	input  imurb_pkg::vec3_t    acc_vec,
	input  imurb_pkg::vec3_t    gyr_vec,
	input  imurb_pkg::vec3_t    cmp_vec,
	input  imurb_pkg::lane_ctl_t ctl,
	input  imurb_pkg::bias_ctl_t bctl,
	output imurb_pkg::lane_sq_t sq,
	output logic signed [15:0]  acc_out,
	output logic signed [15:0]  gyr_out,
	output logic signed [15:0]  cmp_out
);
	import imurb_pkg::*;

	// Dot product of one matrix row with a vector; pattern 10 counts as zero
	function automatic logic signed [15:0] rot_row(input logic [5:0] r, input vec3_t v);
		logic signed [17:0] s;
		logic [1:0]         e;
		s = '0;
		for (int c = 0; c < NUM_AXES; c++) begin
			e = r[2*c +: 2];
			if (e == 2'b01) begin
				s = s + 18'(signed'(v[c]));
			end else if (e == 2'b11) begin
				s = s - 18'(signed'(v[c]));
			end
		end
		if (s > 18'sd32767) begin
			rot_row = 16'sh7FFF;
		end else if (s < -18'sd32768) begin
			rot_row = 16'sh8000;
		end else begin
			rot_row = s[15:0];
		end
	endfunction

	logic signed [15:0] acc_s1, gyr_s1, cmp_s1;
	logic signed [15:0] prev_q;
	logic signed [31:0] bias_q;
	logic signed [49:0] prod_s3;

	logic signed [16:0] d;
	logic signed [33:0] dd;
	logic signed [31:0] gg;
	logic signed [31:0] g28;
	logic signed [32:0] diff;
	logic signed [49:0] prod_r;
	logic signed [34:0] nb;
	logic signed [32:0] bias_r;
	logic signed [17:0] go;

	// Rotate this lane's row of all three vectors
	always_ff @(posedge clk) begin
		if (ctl.rot_en) begin
			acc_s1 <= rot_row(row, acc_vec);
			gyr_s1 <= rot_row(row, gyr_vec);
			cmp_s1 <= rot_row(row, cmp_vec);
		end
	end

	// Square the accel change and the gyro component
	assign d  = 17'(prev_q) - 17'(acc_s1);
	assign dd = 34'(d) * 34'(d);
	assign gg = 32'(gyr_s1) * 32'(gyr_s1);

	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			sq.dsq <= dd[32:0];
			sq.gsq <= gg[30:0];
		end
	end

	// Weight the distance from bias to gyro by alpha
	assign g28  = {gyr_s1, 16'h0000};
	assign diff = 33'(g28) - 33'(bias_q);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s3 <= 50'(diff) * 50'(signed'({1'b0, bctl.alpha}));
		end
	end

	// Round the step, add it to the bias and clamp to 32 bits
	assign prod_r = prod_s3 + 50'sd32768;
	assign nb     = 35'(bias_q) + 35'(signed'(prod_r[49:16]));

	// Hold previous accel and bias state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			bias_q <= '0;
		end else begin
			if (ctl.sq_en) begin
				prev_q <= acc_s1;
			end
			if (ctl.upd_en && bctl.still) begin
				if (nb > 35'sh07FFFFFFF) begin
					bias_q <= 32'sh7FFFFFFF;
				end else if (nb < -35'sh080000000) begin
					bias_q <= 32'sh80000000;
				end else begin
					bias_q <= nb[31:0];
				end
			end
		end
	end

	// Subtract the rounded bias from the rotated gyro and saturate
	assign bias_r = 33'(bias_q) + 33'sd32768;
	assign go     = 18'(gyr_s1) - 18'(signed'(bias_r[32:16]));

	always_comb begin
		if (go > 18'sd32767) begin
			gyr_out = 16'sh7FFF;
		end else if (go < -18'sd32768) begin
			gyr_out = 16'sh8000;
		end else begin
			gyr_out = go[15:0];
		end
	end

	assign acc_out = acc_s1;
	assign cmp_out = cmp_s1;

endmodule

/* src/imurb_merge.sv */
module imurb_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      mrg_en,
	input  imurb_pkg::cfg_t           cfg,
	input  imurb_pkg::lane_sq_t [2:0] sq,
	output imurb_pkg::bias_ctl_t      bctl
);
	import imurb_pkg::*;

	logic [34:0] dsq_sum;
	logic [32:0] gsq_sum;
	logic        still;
	logic [15:0] still_count_q;

	// Sum the lanes' squared terms and test both thresholds
	assign dsq_sum = 35'(sq[0].dsq) + 35'(sq[1].dsq) + 35'(sq[2].dsq);
	assign gsq_sum = 33'(sq[0].gsq) + 33'(sq[1].gsq) + 33'(sq[2].gsq);
	assign still   = (dsq_sum < 35'(cfg.accel_still_sq)) &&
	                 (gsq_sum < 33'(cfg.gyro_still_sq));

	// Pick the fast weight until the learn limit is reached
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_count_q <= '0;
			bctl.still    <= 1'b0;
			bctl.alpha    <= '0;
		end else if (mrg_en) begin
			bctl.still <= still;
			if (still && (still_count_q < cfg.learn_sample_limit)) begin
				still_count_q <= still_count_q + 16'd1;
			end
			if (still_count_q < cfg.learn_sample_limit) begin
				bctl.alpha <= cfg.learn_alpha;
			end else begin
				bctl.alpha <= cfg.track_alpha;
			end
		end
	end

endmodule

/* src/imu_axis_rotate_gyro_bias_top.sv */
// Rotates each IMU sample (accel, gyro, compass) by a configured matrix of
// -1/0/+1 entries, detects stillness from the accel change and gyro magnitude,
// tracks a gyro bias on still samples and returns the rotated vectors with
// the bias taken off the gyro. One lane per axis does the rotation, squaring
// and bias filter, and a merge stage sums the lanes' squares for the
// stillness test. An item passes through six steps from acceptance to the
// result register: rotate, square, merge, multiply, update, output. The
// sequencer holds one item at a time, so in_stall is high until the item
// leaves the output step, and no new item is taken before then; a result left
// waiting in the output register blocks the next one only at its output step.
// Configuration must be written only while the block is idle (not enforced).
module imu_axis_rotate_gyro_bias_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  imurb_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output imurb_pkg::out_item_t out_data
);
	import imurb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_MRG  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]   state_q;
	in_item_t     in_q;
	cfg_t         cfg_q;
	lane_ctl_t    ctl;
	bias_ctl_t    bctl;
	lane_sq_t [2:0] sq;
	vec3_t        acc_v, gyr_v, cmp_v;
	logic signed [15:0] acc_o [3];
	logic signed [15:0] gyr_o [3];
	logic signed [15:0] cmp_o [3];
	logic         in_acc;
	logic         out_load;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation_matrix    <= ROT_MATRIX_RST;
			cfg_q.learn_alpha        <= LEARN_ALPHA_RST;
			cfg_q.track_alpha        <= TRACK_ALPHA_RST;
			cfg_q.learn_sample_limit <= LEARN_LIMIT_RST;
			cfg_q.accel_still_sq     <= ACCEL_STILL_RST;
			cfg_q.gyro_still_sq      <= GYRO_STILL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROT_MATRIX:  cfg_q.rotation_matrix    <= cfg_data[17:0];
				REG_LEARN_ALPHA: cfg_q.learn_alpha        <= cfg_data[15:0];
				REG_TRACK_ALPHA: cfg_q.track_alpha        <= cfg_data[15:0];
				REG_LEARN_LIMIT: cfg_q.learn_sample_limit <= cfg_data[15:0];
				REG_ACCEL_STILL: cfg_q.accel_still_sq     <= cfg_data;
				REG_GYRO_STILL:  cfg_q.gyro_still_sq      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_data;
		end
	end

	// Advance the sequencer one step per cycle, wait at output if full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_ROT;
				ST_ROT:  state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_MRG;
				ST_MRG:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_OUT;
				ST_OUT:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ctl.rot_en = (state_q == ST_ROT);
	assign ctl.sq_en  = (state_q == ST_SQ);
	assign ctl.mul_en = (state_q == ST_MUL);
	assign ctl.upd_en = (state_q == ST_UPD);

	assign acc_v = {in_q.accel_z, in_q.accel_y, in_q.accel_x};
	assign gyr_v = {in_q.gyro_z, in_q.gyro_y, in_q.gyro_x};
	assign cmp_v = {in_q.compass_z, in_q.compass_y, in_q.compass_x};

	// One lane per output axis
	for (genvar r = 0; r < NUM_AXES; r++) begin : g_lane
		imurb_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.row     (cfg_q.rotation_matrix[6*r +: 6]),
			.acc_vec (acc_v),
			.gyr_vec (gyr_v),
			.cmp_vec (cmp_v),
			.ctl     (ctl),
			.bctl    (bctl),
			.sq      (sq[r]),
			.acc_out (acc_o[r]),
			.gyr_out (gyr_o[r]),
			.cmp_out (cmp_o[r])
		);
	end

	imurb_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.mrg_en (state_q == ST_MRG),
		.cfg    (cfg_q),
		.sq     (sq),
		.bctl   (bctl)
	);

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data.accel_out_x   <= acc_o[0];
			out_data.accel_out_y   <= acc_o[1];
			out_data.accel_out_z   <= acc_o[2];
			out_data.gyro_out_x    <= gyr_o[0];
			out_data.gyro_out_y    <= gyr_o[1];
			out_data.gyro_out_z    <= gyr_o[2];
			out_data.compass_out_x <= cmp_o[0];
			out_data.compass_out_y <= cmp_o[1];
			out_data.compass_out_z <= cmp_o[2];
		end
	end

	// A result appears only from the output step
	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result appeared outside the output step");

	// An accepted item starts the rotation step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_ROT))
		else $error("accepted item did not start the sequence");

	// A pending result blocks the next one from being written
	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid && out_stall) |=> (state_q == ST_OUT))
		else $error("sequencer left the output step over a pending result");

endmodule
